// ===== design/tfz_pkg.sv =====
// Shared widths, register codes and the vertex configuration type of the triangle fragment stage.
package tfz_pkg;

    localparam int COORD_W = 16;
    localparam int Z_W     = 24;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 24;
    localparam int POS_W   = 56;
    localparam int W_W     = 32;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int EDGE_W  = PROD_W + 1;
    localparam int DNUM_W  = W_W + Z_W;
    localparam int CNUM_W  = W_W + CH_W;
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int REGIDX_W = 3;

    localparam logic [REGIDX_W-1:0] REG_A_POS = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_B_POS = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_C_POS = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_A_COL = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_B_COL = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_C_COL = 3'd5;

    localparam logic [Z_W-1:0] DEPTH_FAR = '1;

    typedef struct packed {
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
        logic [POS_W-1:0]   pos_c;
        logic [COLOR_W-1:0] col_a;
        logic [COLOR_W-1:0] col_b;
        logic [COLOR_W-1:0] col_c;
    } tfz_cfg_t;

endpackage

// ===== design/tfz_cfg.sv =====
// Configuration register bank with an APB-style access port.
module tfz_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfz_pkg::PADDR_W-1:0]   paddr,
    input  logic [tfz_pkg::PDATA_W-1:0]   pwdata,
    output logic [tfz_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output tfz_pkg::tfz_cfg_t             cfg
);
    import tfz_pkg::*;

    tfz_cfg_t              cfg_reg;
    logic [REGIDX_W-1:0]   idx;
    logic                  wr;

    assign idx    = paddr[PADDR_W-1:PADDR_W-REGIDX_W];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_A_POS: cfg_reg.pos_a <= pwdata[POS_W-1:0];
                REG_B_POS: cfg_reg.pos_b <= pwdata[POS_W-1:0];
                REG_C_POS: cfg_reg.pos_c <= pwdata[POS_W-1:0];
                REG_A_COL: cfg_reg.col_a <= pwdata[COLOR_W-1:0];
                REG_B_COL: cfg_reg.col_b <= pwdata[COLOR_W-1:0];
                REG_C_COL: cfg_reg.col_c <= pwdata[COLOR_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_A_POS: prdata = PDATA_W'(cfg_reg.pos_a);
            REG_B_POS: prdata = PDATA_W'(cfg_reg.pos_b);
            REG_C_POS: prdata = PDATA_W'(cfg_reg.pos_c);
            REG_A_COL: prdata = PDATA_W'(cfg_reg.col_a);
            REG_B_COL: prdata = PDATA_W'(cfg_reg.col_b);
            REG_C_COL: prdata = PDATA_W'(cfg_reg.col_c);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== design/tfz_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tfz_div #(
    parameter int DEN_W = 32,
    parameter int QW    = 24
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DEN_W+QW-1:0]   num,
    input  logic [DEN_W-1:0]      den,
    output logic [QW-1:0]         quo
);
    localparam int CW = DEN_W + QW;

    logic [CW-1:0]    rem_reg [QW];
    logic [DEN_W-1:0] den_reg [QW];
    logic [QW-1:0]    quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [CW-1:0]    rem_in;
        logic [CW-1:0]    dsh;
        logic [DEN_W-1:0] den_in;
        logic [QW-1:0]    quo_in;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign dsh = CW'(den_in) << (QW - 1 - k);
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (rem_in - dsh) : rem_in;
                den_reg[k] <= den_in;
                quo_reg[k] <= QW'({quo_in, ge});
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== design/tfz_zmem.sv =====
// Depth store: one-port-write, one-port-read synchronous memory with a clearing sweep after reset.
module tfz_zmem #(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic [tfz_pkg::Z_W-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [tfz_pkg::Z_W-1:0] wr_data,
    output logic                    busy
);
    import tfz_pkg::*;

    logic [Z_W-1:0]    mem [DEPTH];
    logic [Z_W-1:0]    rd_data_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= DEPTH_FAR;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== design/triangle_fragment_zbuffer.sv =====
// Top level of the z-buffered triangle fragment stage.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | in_valid / in_ready    | pixel_row, pixel_column
//   output   | out_valid / out_ready  | write_pixel, pixel_color, pixel_depth
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata (register i at 8*i)
//
// One pixel transfer per cycle while in_ready is high; the 24-stage depth divider
// feeds the depth store read-modify-write. After reset the depth store is swept to
// far, with in_ready low until the sweep ends. A two-entry output buffer lets the
// pipeline run while a result waits; the pipeline stalls only when both entries are full.
module triangle_fragment_zbuffer #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tfz_pkg::PADDR_W-1:0]      paddr,
    input  logic [tfz_pkg::PDATA_W-1:0]      pwdata,
    output logic [tfz_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [11:0]               pixel_row,
    input  logic signed [11:0]               pixel_column,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             write_pixel,
    output logic [tfz_pkg::COLOR_W-1:0]      pixel_color,
    output logic [tfz_pkg::Z_W-1:0]          pixel_depth
);
    import tfz_pkg::*;

    localparam int STORE_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DIV_LAT     = Z_W;
    localparam int CDLY        = Z_W - CH_W;

    typedef struct packed {
        logic              v;
        logic              keep;
        logic [ADDR_W-1:0] addr;
    } sb_t;

    function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        return $signed({2'b00, a}) - $signed({2'b00, b});
    endfunction

    tfz_cfg_t cfg;
    logic     en;
    logic     busy;
    logic     in_fire;
    logic     skid_valid_reg;
    logic     out_valid_reg;

    tfz_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en       = !skid_valid_reg;
    assign in_ready = en && !busy;
    assign in_fire  = in_valid && in_ready;

    logic [COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic [Z_W-1:0]     az, bz, cz;

    assign ax = cfg.pos_a[15:0];
    assign ay = cfg.pos_a[31:16];
    assign az = cfg.pos_a[55:32];
    assign bx = cfg.pos_b[15:0];
    assign by = cfg.pos_b[31:16];
    assign bz = cfg.pos_b[55:32];
    assign cx = cfg.pos_c[15:0];
    assign cy = cfg.pos_c[31:16];
    assign cz = cfg.pos_c[55:32];

    // Stage 1: pixel centre, image bounds and store address.
    logic               in_img;
    logic               v1_reg, img1_reg;
    logic [ADDR_W-1:0]  addr1_reg;
    logic [COORD_W-1:0] px1_reg, py1_reg;

    assign in_img = !pixel_row[11] && !pixel_column[11]
                 && (32'(pixel_row[10:0]) < 32'(IMAGE_HEIGHT))
                 && (32'(pixel_column[10:0]) < 32'(IMAGE_WIDTH));

    // Stage 2: edge products.
    logic                     v2_reg, img2_reg;
    logic [ADDR_W-1:0]        addr2_reg;
    logic signed [PROD_W-1:0] pr_reg [8];

    // Stage 3: edge values and twice the signed area.
    logic                     v3_reg, img3_reg;
    logic [ADDR_W-1:0]        addr3_reg;
    logic signed [EDGE_W-1:0] ar3_reg, ea3_reg, eb3_reg, ec3_reg;

    // Stage 4: winding fix, inside test, weights.
    logic                     neg;
    logic signed [EDGE_W-1:0] far_s, fea, feb, fec;
    logic                     in_tri;
    logic                     v4_reg, keep4_reg;
    logic [ADDR_W-1:0]        addr4_reg;
    logic [W_W-1:0]           wa4_reg, wb4_reg, wc4_reg, ar4_reg;

    assign neg    = ar3_reg[EDGE_W-1];
    assign far_s  = neg ? -ar3_reg : ar3_reg;
    assign fea    = neg ? -ea3_reg : ea3_reg;
    assign feb    = neg ? -eb3_reg : eb3_reg;
    assign fec    = neg ? -ec3_reg : ec3_reg;
    assign in_tri = !fea[EDGE_W-1] && !feb[EDGE_W-1] && !fec[EDGE_W-1];

    // Stage 5: weighted products.
    logic                 v5_reg, keep5_reg;
    logic [ADDR_W-1:0]    addr5_reg;
    logic [W_W-1:0]       ar5_reg;
    logic [DNUM_W-1:0]    dp5_reg [3];
    logic [CNUM_W-1:0]    cp5_reg [9];

    // Stage 6: rounded numerators.
    logic                 v6_reg, keep6_reg;
    logic [ADDR_W-1:0]    addr6_reg;
    logic [W_W-1:0]       ar6_reg;
    logic [DNUM_W-1:0]    dn6_reg;
    logic [CNUM_W-1:0]    cn6_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            img1_reg  <= in_img;
            addr1_reg <= ADDR_W'(32'(pixel_row[10:0]) * 32'(IMAGE_WIDTH)
                                 + 32'(pixel_column[10:0]));
            px1_reg   <= {1'b0, pixel_column[10:0], 4'h8};
            py1_reg   <= {1'b0, pixel_row[10:0], 4'h8};

            img2_reg  <= img1_reg;
            addr2_reg <= addr1_reg;
            pr_reg[0] <= sdiff(bx, ax) * sdiff(cy, ay);
            pr_reg[1] <= sdiff(by, ay) * sdiff(cx, ax);
            pr_reg[2] <= sdiff(cx, bx) * sdiff(py1_reg, by);
            pr_reg[3] <= sdiff(cy, by) * sdiff(px1_reg, bx);
            pr_reg[4] <= sdiff(ax, cx) * sdiff(py1_reg, cy);
            pr_reg[5] <= sdiff(ay, cy) * sdiff(px1_reg, cx);
            pr_reg[6] <= sdiff(bx, ax) * sdiff(py1_reg, ay);
            pr_reg[7] <= sdiff(by, ay) * sdiff(px1_reg, ax);

            img3_reg  <= img2_reg;
            addr3_reg <= addr2_reg;
            ar3_reg   <= EDGE_W'(pr_reg[0]) - EDGE_W'(pr_reg[1]);
            ea3_reg   <= EDGE_W'(pr_reg[2]) - EDGE_W'(pr_reg[3]);
            eb3_reg   <= EDGE_W'(pr_reg[4]) - EDGE_W'(pr_reg[5]);
            ec3_reg   <= EDGE_W'(pr_reg[6]) - EDGE_W'(pr_reg[7]);

            keep4_reg <= img3_reg && (ar3_reg != '0) && in_tri;
            addr4_reg <= addr3_reg;
            wa4_reg   <= fea[W_W-1:0];
            wb4_reg   <= feb[W_W-1:0];
            wc4_reg   <= fec[W_W-1:0];
            ar4_reg   <= far_s[W_W-1:0];

            keep5_reg  <= keep4_reg;
            addr5_reg  <= addr4_reg;
            ar5_reg    <= ar4_reg;
            dp5_reg[0] <= wa4_reg * az;
            dp5_reg[1] <= wb4_reg * bz;
            dp5_reg[2] <= wc4_reg * cz;
            for (int c = 0; c < 3; c++)
            begin
                cp5_reg[3*c]   <= wa4_reg * cfg.col_a[CH_W*c +: CH_W];
                cp5_reg[3*c+1] <= wb4_reg * cfg.col_b[CH_W*c +: CH_W];
                cp5_reg[3*c+2] <= wc4_reg * cfg.col_c[CH_W*c +: CH_W];
            end

            keep6_reg <= keep5_reg;
            addr6_reg <= addr5_reg;
            ar6_reg   <= ar5_reg;
            dn6_reg   <= dp5_reg[0] + dp5_reg[1] + dp5_reg[2] + DNUM_W'(ar5_reg >> 1);
            for (int c = 0; c < 3; c++)
            begin
                cn6_reg[c] <= cp5_reg[3*c] + cp5_reg[3*c+1] + cp5_reg[3*c+2]
                            + CNUM_W'(ar5_reg >> 1);
            end
        end
    end

    // Division stages.
    logic [Z_W-1:0]  dq;
    logic [CH_W-1:0] cq [3];

    tfz_div #(.DEN_W(W_W), .QW(Z_W)) u_div_z (
        .clk (clk),
        .en  (en),
        .num (dn6_reg),
        .den (ar6_reg),
        .quo (dq)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_cdiv
        tfz_div #(.DEN_W(W_W), .QW(CH_W)) u_div_c (
            .clk (clk),
            .en  (en),
            .num (cn6_reg[c]),
            .den (ar6_reg),
            .quo (cq[c])
        );
    end

    sb_t                sb_reg   [DIV_LAT];
    logic [COLOR_W-1:0] cdly_reg [CDLY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            sb_reg[0] <= '{v: v6_reg, keep: keep6_reg, addr: addr6_reg};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdly_reg[0] <= {cq[2], cq[1], cq[0]};
            for (int i = 1; i < CDLY; i++)
            begin
                cdly_reg[i] <= cdly_reg[i-1];
            end
        end
    end

    // Depth test against the store, with forwarding of the previous write.
    sb_t               sbc;
    logic [Z_W-1:0]    rd_data;
    logic [Z_W-1:0]    stored;
    logic              pass;
    logic              wr_en;
    logic              push;
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [Z_W-1:0]    lw_data_reg;

    assign sbc    = sb_reg[DIV_LAT-1];
    assign stored = (lw_valid_reg && (lw_addr_reg == sbc.addr)) ? lw_data_reg : rd_data;
    assign pass   = sbc.v && sbc.keep && (dq < stored);
    assign wr_en  = en && pass;
    assign push   = en && sbc.v;

    tfz_zmem #(.DEPTH(STORE_DEPTH), .ADDR_W(ADDR_W)) u_zmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (en),
        .rd_addr (sb_reg[DIV_LAT-2].addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (sbc.addr),
        .wr_data (dq),
        .busy    (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            lw_valid_reg <= pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lw_addr_reg <= sbc.addr;
            lw_data_reg <= dq;
        end
    end

    // Output register and skid entry.
    logic               res_wp;
    logic [COLOR_W-1:0] res_col;
    logic [Z_W-1:0]     res_z;
    logic               out_wp_reg, skid_wp_reg;
    logic [COLOR_W-1:0] out_col_reg, skid_col_reg;
    logic [Z_W-1:0]     out_z_reg, skid_z_reg;

    assign res_wp  = pass;
    assign res_col = pass ? cdly_reg[CDLY-1] : '0;
    assign res_z   = pass ? dq : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_wp_reg  <= skid_wp_reg;
                out_col_reg <= skid_col_reg;
                out_z_reg   <= skid_z_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_wp_reg  <= res_wp;
                skid_col_reg <= res_col;
                skid_z_reg   <= res_z;
            end
            else
            begin
                out_wp_reg  <= res_wp;
                out_col_reg <= res_col;
                out_z_reg   <= res_z;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_pixel = out_wp_reg;
    assign pixel_color = out_col_reg;
    assign pixel_depth = out_z_reg;

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("pixel taken while the depth store is being cleared");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_wp_reg) |-> (out_col_reg == '0 && out_z_reg == '0))
        else $error("result without a write carries nonzero color or depth");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("result arriving at a stalled output was not buffered");

endmodule
